>>> hw/rtl/rsos_pkg.sv
// ---------------------------------------------------------------------------
// rsos_pkg
// Shared types, codes and constants of the range scan object segmenter.
// ---------------------------------------------------------------------------
`default_nettype none

package rsos_pkg;

  // field widths
  localparam int DIST_W    = 12;
  localparam int ANG_W     = 8;
  localparam int FUNC_W    = 2;
  localparam int CNT_OUT_W = 3;
  localparam int IDX_OUT_W = 3;
  localparam int CFG_IDX_W = 3;

  // object table and report limits
  localparam int MAX_OBJECTS_DEF = 5;
  localparam int RESULT_CAP      = 5;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WINDOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_VALUE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAX      = 3'd5;

  // configuration reset values
  localparam logic [DIST_W-1:0] EDGE_THRESHOLD_RST = 12'd480;
  localparam logic [DIST_W-1:0] SMOOTH_WINDOW_RST  = 12'd320;
  localparam logic [DIST_W-1:0] FAR_LIMIT_RST      = 12'd1600;
  localparam logic [DIST_W-1:0] FAR_VALUE_RST      = 12'd4000;
  localparam logic [ANG_W-1:0]  WIDTH_MIN_RST      = 8'd2;
  localparam logic [ANG_W-1:0]  WIDTH_MAX_RST      = 8'd75;

  // divide by three as multiply by ceil(2^16/3) and shift; exact for sums below 2^14
  localparam int            SUM3_W      = 14;
  localparam int            RECIP_W     = 15;
  localparam int            RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] THIRD_RECIP = 15'd21846;

  // edges are only tracked past this angle
  localparam logic [ANG_W-1:0] EDGE_MIN_ANGLE = 8'd4;
  // second seed sits this many degrees after the first
  localparam logic [ANG_W-1:0] SEED_STEP = 8'd2;

  // classified command handed from front to back
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ANG_W-1:0]  angle;
    logic [DIST_W-1:0] dist_a;  // clamped mean on a sample, first seed on start
    logic [DIST_W-1:0] dist_b;  // second seed on start
  } cmd_t;

  // configuration seen by the back part
  typedef struct packed {
    logic [DIST_W-1:0] edge_threshold;
    logic [DIST_W-1:0] smooth_window;
    logic [ANG_W-1:0]  width_min;
    logic [ANG_W-1:0]  width_max;
  } back_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/rsos_front.sv
// ---------------------------------------------------------------------------
// rsos_front
// Accepts items, forms the trimmed mean of the five readings, swaps in the far
// value above the far limit and hands a classified command to the command queue.
// ---------------------------------------------------------------------------
`default_nettype none

module rsos_front
  import rsos_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic [ANG_W-1:0]  angle,
  input  wire logic [DIST_W-1:0] reading_a,
  input  wire logic [DIST_W-1:0] reading_b,
  input  wire logic [DIST_W-1:0] reading_c,
  input  wire logic [DIST_W-1:0] reading_d,
  input  wire logic [DIST_W-1:0] reading_e,
  input  wire logic [DIST_W-1:0] far_limit,
  input  wire logic [DIST_W-1:0] far_value,
  output cmd_t                   cmd_out,
  output logic                   cmd_push,
  input  wire logic              cmd_full
);

  localparam int NRD   = 5;
  localparam int SUM_W = DIST_W + 3;
  localparam int PROD_W = SUM3_W + RECIP_W;

  // stage 1: min, max and sum of the middle three
  logic              s1_valid;
  logic [FUNC_W-1:0] s1_func;
  logic [ANG_W-1:0]  s1_angle;
  logic [DIST_W-1:0] s1_a;
  logic [DIST_W-1:0] s1_b;
  logic [SUM3_W-1:0] s1_sum3;

  // stage 2: mean after the reciprocal multiply
  logic              s2_valid;
  logic [FUNC_W-1:0] s2_func;
  logic [ANG_W-1:0]  s2_angle;
  logic [DIST_W-1:0] s2_a;
  logic [DIST_W-1:0] s2_b;
  logic [DIST_W-1:0] s2_mean;

  logic              adv2;
  logic [SUM3_W-1:0] sum3;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] clamped;

  // trim the extremes off the five readings
  always_comb begin
    logic [DIST_W-1:0] rd [NRD];
    logic [DIST_W-1:0] mn;
    logic [DIST_W-1:0] mx;
    logic [SUM_W-1:0]  sum5;
    rd[0] = reading_a;
    rd[1] = reading_b;
    rd[2] = reading_c;
    rd[3] = reading_d;
    rd[4] = reading_e;
    mn   = rd[0];
    mx   = rd[0];
    sum5 = SUM_W'(rd[0]);
    for (int i = 1; i < NRD; i++) begin
      if (rd[i] < mn) mn = rd[i];
      if (rd[i] > mx) mx = rd[i];
      sum5 = sum5 + SUM_W'(rd[i]);
    end
    sum3 = SUM3_W'(sum5 - SUM_W'(mn) - SUM_W'(mx));
  end

  // stage handshake
  assign adv2 = !s2_valid || !cmd_full;
  assign full = s1_valid && !adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!full) begin
      s1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!full) begin
      s1_func  <= func;
      s1_angle <= angle;
      s1_a     <= reading_a;
      s1_b     <= reading_b;
      s1_sum3  <= sum3;
    end
  end

  assign prod = PROD_W'(s1_sum3) * PROD_W'(THIRD_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_func  <= s1_func;
      s2_angle <= s1_angle;
      s2_a     <= s1_a;
      s2_b     <= s1_b;
      s2_mean  <= DIST_W'(prod >> RECIP_SHIFT);
    end
  end

  // far readings count as empty space
  assign clamped = (s2_mean > far_limit) ? far_value : s2_mean;

  always_comb begin
    cmd_out.func   = s2_func;
    cmd_out.angle  = s2_angle;
    cmd_out.dist_a = (s2_func == FUNC_SAMPLE) ? clamped : s2_a;
    cmd_out.dist_b = s2_b;
  end

  assign cmd_push = s2_valid;

endmodule

`default_nettype wire

>>> hw/rtl/rsos_cmd_queue.sv
// ---------------------------------------------------------------------------
// rsos_cmd_queue
// Short queue of classified commands between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module rsos_cmd_queue
  import rsos_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t wr_data,
  input  wire logic wr_en,
  output logic      full,
  output cmd_t      rd_data,
  output logic      empty,
  input  wire logic rd_en
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_DEPTH - 1);

  cmd_t             mem [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign full  = (fill == CNT_W'(CMD_DEPTH));
  assign empty = (fill == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (do_wr && !do_rd) fill <= fill + CNT_W'(1);
      else if (do_rd && !do_wr) fill <= fill - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rsos_back.sv
// ---------------------------------------------------------------------------
// rsos_back
// Carries out commands: keeps the sweep state, smooths, detects edges,
// records objects and walks the object table on a finish command.
// ---------------------------------------------------------------------------
`default_nettype none

module rsos_back
  import rsos_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire back_cfg_t            cfg,
  input  wire cmd_t                 cmd,
  input  wire logic                 cmd_empty,
  output logic                      cmd_pop,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [DIST_W-1:0]         filtered_distance,
  output logic [CNT_OUT_W-1:0]      objects_found,
  output logic                      object_valid,
  output logic [IDX_OUT_W-1:0]      object_index,
  output logic [ANG_W-1:0]          start_angle,
  output logic [ANG_W-1:0]          end_angle,
  output logic [ANG_W-1:0]          mid_angle,
  output logic                      last
);

  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int LW    = CNT_W + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  // sweep state
  logic [DIST_W-1:0] older_distance;
  logic [DIST_W-1:0] newer_distance;
  logic [ANG_W-1:0]  older_angle;
  logic [ANG_W-1:0]  newer_angle;
  logic              recording;
  logic [CNT_W-1:0]  count;
  logic [ANG_W-1:0]  cur_start;

  // object table, undefined until written
  logic [ANG_W-1:0] tab_start [MAX_OBJECTS];
  logic [ANG_W-1:0] tab_end   [MAX_OBJECTS];

  logic             state;
  logic [IDX_W-1:0] walk;

  // result register
  logic res_full;
  logic can_load;
  logic exec;
  logic load;

  assign can_load = !res_full || pop;
  assign exec     = (state == ST_IDLE) && !cmd_empty && can_load;
  assign load     = exec || ((state == ST_WALK) && can_load);
  assign cmd_pop  = exec;
  assign empty    = !res_full;

  // smoothing of the middle point
  logic [DIST_W:0]   sum_oc;
  logic              agree;
  logic [DIST_W-1:0] mid_dist;

  assign sum_oc = {1'b0, older_distance} + {1'b0, cmd.dist_a};
  assign agree  = ({1'b0, older_distance} < ({1'b0, cmd.dist_a} + {1'b0, cfg.smooth_window}))
               && (({1'b0, older_distance} + {1'b0, cfg.smooth_window}) > {1'b0, cmd.dist_a});
  assign mid_dist = agree ? sum_oc[DIST_W:1] : newer_distance;

  // edge detection and width check
  logic             edge_ok;
  logic             fall;
  logic             rise;
  logic             open_obj;
  logic             close_try;
  logic [ANG_W-1:0] obj_width;
  logic             wide_ok;
  logic             counted;

  assign edge_ok   = (int'(count) < MAX_OBJECTS) && (cmd.angle > EDGE_MIN_ANGLE);
  assign fall      = ({1'b0, mid_dist} + {1'b0, cfg.edge_threshold}) <= {1'b0, older_distance};
  assign rise      = {1'b0, mid_dist} >= ({1'b0, older_distance} + {1'b0, cfg.edge_threshold});
  assign open_obj  = edge_ok && fall && !recording;
  assign close_try = edge_ok && rise && recording;
  assign obj_width = older_angle - cur_start;
  assign wide_ok   = (older_angle > cur_start) && (obj_width > cfg.width_min)
                  && (obj_width < cfg.width_max);
  assign counted   = exec && (cmd.func == FUNC_SAMPLE) && close_try && wide_ok;

  // report walk over the table
  logic [CNT_W-1:0] rep_n;
  logic [IDX_W-1:0] emit_idx;
  logic [LW-1:0]    walk_nx;
  logic             walk_last;
  logic [ANG_W-1:0] rd_start;
  logic [ANG_W-1:0] rd_end;
  logic [ANG_W-1:0] rd_span;

  assign rep_n     = (int'(count) > RESULT_CAP) ? CNT_W'(RESULT_CAP) : count;
  assign emit_idx  = (state == ST_IDLE) ? '0 : walk;
  assign walk_nx   = LW'(emit_idx) + LW'(1);
  assign walk_last = (walk_nx == LW'(rep_n));
  assign rd_start  = tab_start[emit_idx];
  assign rd_end    = tab_end[emit_idx];
  assign rd_span   = rd_end - rd_start;

  // table writes on a counted object
  always_ff @(posedge clk) begin
    if (counted) begin
      tab_start[count[IDX_W-1:0]] <= cur_start;
      tab_end[count[IDX_W-1:0]]   <= older_angle;
    end
    if (exec && (cmd.func == FUNC_SAMPLE) && open_obj) begin
      cur_start <= older_angle;
    end
  end

  // sweep state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      older_distance <= '0;
      newer_distance <= '0;
      older_angle    <= '0;
      newer_angle    <= '0;
      recording      <= 1'b0;
      count          <= '0;
      state          <= ST_IDLE;
      walk           <= '0;
      res_full       <= 1'b0;
    end else begin
      res_full <= load || (res_full && !pop);
      case (state)
        ST_IDLE: begin
          if (exec) begin
            case (cmd.func)
              FUNC_START: begin
                older_distance <= cmd.dist_a;
                newer_distance <= cmd.dist_b;
                older_angle    <= cmd.angle;
                newer_angle    <= cmd.angle + SEED_STEP;
                recording      <= 1'b0;
                count          <= '0;
              end
              FUNC_SAMPLE: begin
                if (open_obj) recording <= 1'b1;
                if (counted) begin
                  recording <= 1'b0;
                  count     <= count + CNT_W'(1);
                end
                older_distance <= mid_dist;
                newer_distance <= cmd.dist_a;
                older_angle    <= newer_angle;
                newer_angle    <= cmd.angle;
              end
              FUNC_FINISH: begin
                if ((rep_n != '0) && !walk_last) begin
                  state <= ST_WALK;
                  walk  <= IDX_W'(walk_nx);
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_WALK: begin
          if (can_load) begin
            if (walk_last) state <= ST_IDLE;
            else walk <= IDX_W'(walk_nx);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      filtered_distance <= '0;
      objects_found     <= CNT_OUT_W'(count);
      object_valid      <= 1'b0;
      object_index      <= '0;
      start_angle       <= '0;
      end_angle         <= '0;
      mid_angle         <= '0;
      last              <= 1'b1;
      if (exec && (cmd.func == FUNC_START)) begin
        objects_found <= '0;
      end
      if (exec && (cmd.func == FUNC_SAMPLE)) begin
        filtered_distance <= cmd.dist_a;
        objects_found     <= CNT_OUT_W'(counted ? count + CNT_W'(1) : count);
      end
      if ((state == ST_WALK) || (cmd.func == FUNC_FINISH && rep_n != '0)) begin
        object_valid <= 1'b1;
        object_index <= IDX_OUT_W'(emit_idx);
        start_angle  <= rd_start;
        end_angle    <= rd_end;
        mid_angle    <= rd_start + (rd_span >> 1);
        last         <= walk_last;
      end
    end
  end

  // checks on the object bookkeeping
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_OBJECTS)
    else $error("object count beyond table depth");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (walk != '0) && (LW'(walk) < LW'(rep_n)))
    else $error("table walk index out of range");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (exec && cmd.func == FUNC_START) |=> (count == '0) && !recording)
    else $error("start command did not clear the scan");

  a_count_ends_rec: assert property (@(posedge clk) disable iff (rst)
    counted |=> !recording && (count == $past(count) + CNT_W'(1)))
    else $error("counted object left recording on");

endmodule

`default_nettype wire

>>> hw/rtl/range_scan_object_segmenter_core.sv
// ---------------------------------------------------------------------------
// range_scan_object_segmenter_core
// Cuts a sweep of range readings into objects and reports their angles.
// ---------------------------------------------------------------------------
// A start transaction seeds two points and clears the object count, each
// sample transaction yields one result with its clamped trimmed mean, and a
// finish transaction yields one result per counted object (at most five,
// last marked) or a single empty one. The front stages take one item per
// cycle unless the command queue holds them back; the back part reads the
// object table for a finish item one entry per cycle while the result
// register can take it. A two-entry command queue and a single result
// register let either side stall on its own.
`default_nettype none

module range_scan_object_segmenter_core
  import rsos_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // items
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [ANG_W-1:0]     angle,
  input  wire logic [DIST_W-1:0]    reading_a,
  input  wire logic [DIST_W-1:0]    reading_b,
  input  wire logic [DIST_W-1:0]    reading_c,
  input  wire logic [DIST_W-1:0]    reading_d,
  input  wire logic [DIST_W-1:0]    reading_e,
  // results
  output logic                      empty,
  input  wire logic                 pop,
  output logic [DIST_W-1:0]         filtered_distance,
  output logic [CNT_OUT_W-1:0]      objects_found,
  output logic                      object_valid,
  output logic [IDX_OUT_W-1:0]      object_index,
  output logic [ANG_W-1:0]          start_angle,
  output logic [ANG_W-1:0]          end_angle,
  output logic [ANG_W-1:0]          mid_angle,
  output logic                      last,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIST_W-1:0]    cfg_data
);

  logic [DIST_W-1:0] edge_threshold;
  logic [DIST_W-1:0] smooth_window;
  logic [DIST_W-1:0] far_limit;
  logic [DIST_W-1:0] far_value;
  logic [ANG_W-1:0]  width_min;
  logic [ANG_W-1:0]  width_max;
  back_cfg_t         back_cfg;

  cmd_t cmd_wr;
  cmd_t cmd_rd;
  logic cmd_push;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= EDGE_THRESHOLD_RST;
      smooth_window  <= SMOOTH_WINDOW_RST;
      far_limit      <= FAR_LIMIT_RST;
      far_value      <= FAR_VALUE_RST;
      width_min      <= WIDTH_MIN_RST;
      width_max      <= WIDTH_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EDGE_THRESHOLD: edge_threshold <= cfg_data;
        CFG_SMOOTH_WINDOW:  smooth_window  <= cfg_data;
        CFG_FAR_LIMIT:      far_limit      <= cfg_data;
        CFG_FAR_VALUE:      far_value      <= cfg_data;
        CFG_WIDTH_MIN:      width_min      <= cfg_data[ANG_W-1:0];
        CFG_WIDTH_MAX:      width_max      <= cfg_data[ANG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    back_cfg.edge_threshold = edge_threshold;
    back_cfg.smooth_window  = smooth_window;
    back_cfg.width_min      = width_min;
    back_cfg.width_max      = width_max;
  end

  // front: trimmed mean and classification
  rsos_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .angle     (angle),
    .reading_a (reading_a),
    .reading_b (reading_b),
    .reading_c (reading_c),
    .reading_d (reading_d),
    .reading_e (reading_e),
    .far_limit (far_limit),
    .far_value (far_value),
    .cmd_out   (cmd_wr),
    .cmd_push  (cmd_push),
    .cmd_full  (cmd_full)
  );

  // command queue
  rsos_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_data (cmd_wr),
    .wr_en   (cmd_push),
    .full    (cmd_full),
    .rd_data (cmd_rd),
    .empty   (cmd_empty),
    .rd_en   (cmd_pop)
  );

  // back: sweep state, objects and reporting
  rsos_back #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (back_cfg),
    .cmd               (cmd_rd),
    .cmd_empty         (cmd_empty),
    .cmd_pop           (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .filtered_distance (filtered_distance),
    .objects_found     (objects_found),
    .object_valid      (object_valid),
    .object_index      (object_index),
    .start_angle       (start_angle),
    .end_angle         (end_angle),
    .mid_angle         (mid_angle),
    .last              (last)
  );

endmodule

`default_nettype wire
